// ----- design/psq_pkg.sv -----
package psq_pkg;

   // Storage geometry of the list.
   localparam int DEPTH = 16;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int POS_W = 8;
   localparam int DATA_W = 32;
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   // Request kinds.
   typedef enum logic [2:0] {
      KIND_INS_FRONT = 3'd0,
      KIND_INS_END   = 3'd1,
      KIND_INS_POS   = 3'd2,
      KIND_DEL_FRONT = 3'd3,
      KIND_DEL_END   = 3'd4,
      KIND_DEL_POS   = 3'd5
   } kind_type;

   // Response status codes.
   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_EMPTY  = 2'd1,
      ST_FULL   = 2'd2,
      ST_BADPOS = 2'd3
   } status_type;

   // Command broadcast from the controller to every cell in the row.
   typedef struct packed {
      logic                     ins;
      logic                     del;
      logic [IDX_W-1:0]         idx;
      logic signed [DATA_W-1:0] value;
   } cell_ctl_type;

endpackage

// ----- design/psq_cell.sv -----
module psq_cell (
   input  logic                                      clock,
   input  psq_pkg::cell_ctl_type                     ctl,
   input  logic [psq_pkg::IDX_W-1:0]                 slot,
   input  logic signed [psq_pkg::DATA_W-1:0]         left_data,
   input  logic signed [psq_pkg::DATA_W-1:0]         right_data,
   output logic signed [psq_pkg::DATA_W-1:0]         data,
   output logic signed [psq_pkg::DATA_W-1:0]         tap_data
);

   logic signed [psq_pkg::DATA_W-1:0] data_ff;
   logic signed [psq_pkg::DATA_W-1:0] data_in;

   // Inserts move entries up one slot, deletes pull them down one slot.
   always_comb begin
      data_in = data_ff;
      if (ctl.ins) begin
         if (slot > ctl.idx) begin
            data_in = left_data;
         end else if (slot == ctl.idx) begin
            data_in = ctl.value;
         end
      end else if (ctl.del && (slot >= ctl.idx)) begin
         data_in = right_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // Offer the held entry on the removal bus when this slot is addressed.
   assign data = data_ff;
   assign tap_data = (slot == ctl.idx) ? data_ff : '0;

endmodule

// ----- design/psq_ctrl.sv -----
module psq_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  logic [2:0]                           kind,
   input  logic signed [psq_pkg::DATA_W-1:0]    value,
   input  logic [psq_pkg::POS_W-1:0]            position,
   output psq_pkg::cell_ctl_type                ctl,
   output psq_pkg::status_type                  status,
   output logic                                 del_ok
);

   logic [psq_pkg::CNT_W-1:0] count_ff;
   logic [psq_pkg::CNT_W-1:0] count_in;
   logic [psq_pkg::CMP_W-1:0] pos_w;
   logic [psq_pkg::CMP_W-1:0] cnt_w;
   logic [psq_pkg::CMP_W-1:0] pos_m1;
   logic                      full;
   logic                      empty;
   logic                      ins_ok;

   assign pos_w  = psq_pkg::CMP_W'(position);
   assign cnt_w  = psq_pkg::CMP_W'(count_ff);
   assign pos_m1 = pos_w - psq_pkg::CMP_W'(1);
   assign full   = (count_ff == psq_pkg::CNT_W'(psq_pkg::DEPTH));
   assign empty  = (count_ff == '0);

   // Decode the request into a slot index and a status.
   always_comb begin
      ins_ok    = 1'b0;
      del_ok    = 1'b0;
      status    = psq_pkg::ST_OK;
      ctl.value = value;
      ctl.idx   = '0;
      case (psq_pkg::kind_type'(kind))
         psq_pkg::KIND_INS_FRONT: begin
            if (full) status = psq_pkg::ST_FULL;
            else ins_ok = 1'b1;
         end
         psq_pkg::KIND_INS_END: begin
            ctl.idx = psq_pkg::IDX_W'(count_ff);
            if (full) status = psq_pkg::ST_FULL;
            else ins_ok = 1'b1;
         end
         psq_pkg::KIND_INS_POS: begin
            ctl.idx = psq_pkg::IDX_W'(pos_m1);
            if (full) begin
               status = psq_pkg::ST_FULL;
            end else if ((pos_w == '0) || (pos_w > cnt_w + psq_pkg::CMP_W'(1))) begin
               status = psq_pkg::ST_BADPOS;
            end else begin
               ins_ok = 1'b1;
            end
         end
         psq_pkg::KIND_DEL_FRONT: begin
            if (empty) status = psq_pkg::ST_EMPTY;
            else del_ok = 1'b1;
         end
         psq_pkg::KIND_DEL_END: begin
            ctl.idx = psq_pkg::IDX_W'(count_ff - psq_pkg::CNT_W'(1));
            if (empty) status = psq_pkg::ST_EMPTY;
            else del_ok = 1'b1;
         end
         psq_pkg::KIND_DEL_POS: begin
            ctl.idx = psq_pkg::IDX_W'(pos_m1);
            if (empty) begin
               status = psq_pkg::ST_EMPTY;
            end else if ((pos_w == '0) || (pos_w > cnt_w)) begin
               status = psq_pkg::ST_BADPOS;
            end else begin
               del_ok = 1'b1;
            end
         end
         default: begin
            status = psq_pkg::ST_OK;
         end
      endcase
      ctl.ins = accept && ins_ok;
      ctl.del = accept && del_ok;
   end

   // Entry count tracks successful inserts and deletes.
   always_comb begin
      count_in = count_ff;
      if (ctl.ins) count_in = count_ff + psq_pkg::CNT_W'(1);
      else if (ctl.del) count_in = count_ff - psq_pkg::CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ----- design/positional_sequence_store_unit.sv -----
// Positional list store: insert or delete at front, end or a 1-based position.
// The response strobes in the cycle after the transaction is accepted.
// Throughput: one transaction per cycle; busy stays low, since the row of cells
// shifts every entry at or beyond the addressed slot together.
// Reset: synchronous, active high; it empties the list and clears the strobe.
// The receiver cannot stall; each response is valid for exactly one cycle.
module positional_sequence_store_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [2:0]                           req_kind,
   input  logic signed [psq_pkg::DATA_W-1:0]    req_value,
   input  logic [psq_pkg::POS_W-1:0]            req_position,
   output logic                                 rsp_valid,
   output logic signed [psq_pkg::DATA_W-1:0]    rsp_removed,
   output logic [1:0]                           rsp_status
);

   psq_pkg::cell_ctl_type              ctl;
   psq_pkg::status_type                status;
   logic                               del_ok;
   logic                               accept;
   logic signed [psq_pkg::DATA_W-1:0]  cell_data [psq_pkg::DEPTH];
   logic signed [psq_pkg::DATA_W-1:0]  tap_data  [psq_pkg::DEPTH];
   logic signed [psq_pkg::DATA_W-1:0]  tap_or;
   logic                               rsp_valid_ff;
   logic signed [psq_pkg::DATA_W-1:0]  rsp_removed_ff;
   logic [1:0]                         rsp_status_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   psq_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .kind     (req_kind),
      .value    (req_value),
      .position (req_position),
      .ctl      (ctl),
      .status   (status),
      .del_ok   (del_ok)
   );

   // Row of cells; each neighbor feeds the shift in either direction.
   for (genvar g = 0; g < psq_pkg::DEPTH; g++) begin : g_cell
      logic signed [psq_pkg::DATA_W-1:0] left_data;
      logic signed [psq_pkg::DATA_W-1:0] right_data;
      if (g == 0) begin : g_first
         assign left_data = '0;
      end else begin : g_mid
         assign left_data = cell_data[g-1];
      end
      if (g == psq_pkg::DEPTH - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_inner
         assign right_data = cell_data[g+1];
      end
      psq_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .slot       (psq_pkg::IDX_W'(g)),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[g]),
         .tap_data   (tap_data[g])
      );
   end

   // Only the addressed cell drives its entry, so an OR collects it.
   always_comb begin
      tap_or = '0;
      for (int i = 0; i < psq_pkg::DEPTH; i++) begin
         tap_or = tap_or | tap_data[i];
      end
   end

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
      end
      rsp_removed_ff <= del_ok ? tap_or : '0;
      rsp_status_ff  <= status;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_removed = rsp_removed_ff;
   assign rsp_status  = rsp_status_ff;

endmodule

// ----- design/psq_checker.sv -----
module psq_port_assertions (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 start,
   input logic                                 busy,
   input logic [2:0]                           req_kind,
   input logic                                 rsp_valid,
   input logic signed [psq_pkg::DATA_W-1:0]    rsp_removed,
   input logic [1:0]                           rsp_status
);

   // Every accepted transaction yields exactly one response in the following cycle.
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> rsp_valid)
      else $error("accepted transaction got no response");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> !rsp_valid)
      else $error("response without a transaction");

   // A failed request never reports a removed value.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != psq_pkg::ST_OK)) |-> (rsp_removed == '0))
      else $error("error response carries a removed value");

   // Inserts never report a removed value.
   a_ins_zero: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_kind == psq_pkg::KIND_INS_FRONT ||
       req_kind == psq_pkg::KIND_INS_END || req_kind == psq_pkg::KIND_INS_POS))
      |=> (rsp_removed == '0))
      else $error("insert reported a removed value");

   // The list is empty right after reset.
   a_empty_after_reset: assert property (@(posedge clock)
      reset ##1 (!reset && start && !busy && req_kind == psq_pkg::KIND_DEL_FRONT)
      |=> (rsp_valid && rsp_status == psq_pkg::ST_EMPTY))
      else $error("list not empty after reset");

endmodule

bind positional_sequence_store_unit psq_port_assertions u_psq_port_assertions (.*);

// ----- sim/psq_checker.sv -----
module psq_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 busy,
   input  logic [2:0]                           req_kind,
   input  logic signed [psq_pkg::DATA_W-1:0]    req_value,
   input  logic [psq_pkg::POS_W-1:0]            req_position,
   input  logic                                 rsp_valid,
   input  logic signed [psq_pkg::DATA_W-1:0]    rsp_removed,
   input  logic [1:0]                           rsp_status,
   output int                                   failures,
   output int                                   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   // What one transaction is expected to return.
   typedef struct packed {
      logic signed [psq_pkg::DATA_W-1:0] removed;
      psq_pkg::status_type               status;
   } outcome_type;

   // Model of the list contents, front first, and the responses still due.
   logic signed [psq_pkg::DATA_W-1:0] stored_values[$];
   outcome_type                       awaited_outcomes[$];
   int                                mismatch_tally = 0;

   // Applies one request to the list model and returns the response it must give.
   // Errors leave the list untouched; fullness and emptiness win over the position.
   function automatic outcome_type predict_outcome(logic [2:0] kind,
                                                   logic signed [psq_pkg::DATA_W-1:0] value,
                                                   logic [psq_pkg::POS_W-1:0] position);
      outcome_type res;
      int          fill;
      int          slot;
      res.removed = '0;
      res.status = psq_pkg::ST_OK;
      fill = stored_values.size();
      slot = int'(position) - 1;
      case (kind)
         psq_pkg::KIND_INS_FRONT, psq_pkg::KIND_INS_END, psq_pkg::KIND_INS_POS: begin
            if (fill >= psq_pkg::DEPTH) begin
               res.status = psq_pkg::ST_FULL;
            end else if (kind == psq_pkg::KIND_INS_FRONT) begin
               stored_values.push_front(value);
            end else if (kind == psq_pkg::KIND_INS_END) begin
               stored_values.push_back(value);
            end else if (slot < 0 || slot > fill) begin
               res.status = psq_pkg::ST_BADPOS;
            end else begin
               stored_values.insert(slot, value);
            end
         end
         psq_pkg::KIND_DEL_FRONT, psq_pkg::KIND_DEL_END, psq_pkg::KIND_DEL_POS: begin
            if (fill == 0) begin
               res.status = psq_pkg::ST_EMPTY;
            end else if (kind == psq_pkg::KIND_DEL_FRONT) begin
               res.removed = stored_values.pop_front();
            end else if (kind == psq_pkg::KIND_DEL_END) begin
               res.removed = stored_values.pop_back();
            end else if (slot < 0 || slot >= fill) begin
               res.status = psq_pkg::ST_BADPOS;
            end else begin
               res.removed = stored_values[slot];
               stored_values.delete(slot);
            end
         end
         default: begin
            // Spare kinds do nothing and report success.
         end
      endcase
      return res;
   endfunction

   // Responses are retired before new transactions are queued, since a response
   // and the next transaction can share a clock edge.
   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         stored_values.delete();
         awaited_outcomes.delete();
      end else begin
         if (rsp_valid) begin
            if (awaited_outcomes.size() == 0) begin
               mismatch_tally++;
               $display("%0t: response with none outstanding: removed %0d status %0d",
                        $realtime, rsp_removed, rsp_status);
            end else begin
               want = awaited_outcomes.pop_front();
               if (rsp_removed !== want.removed) begin
                  mismatch_tally++;
                  $display("%0t: removed mismatch: expected %0d, actual %0d",
                           $realtime, want.removed, rsp_removed);
               end
               if (rsp_status !== want.status) begin
                  mismatch_tally++;
                  $display("%0t: status mismatch: expected %0d, actual %0d",
                           $realtime, want.status, rsp_status);
               end
            end
         end
         if (start && !busy) begin
            awaited_outcomes.push_back(predict_outcome(req_kind, req_value, req_position));
         end
      end
      pending <= awaited_outcomes.size();
      failures <= mismatch_tally;
   end

endmodule

// ----- sim/positional_sequence_store_unit_test.sv -----
module positional_sequence_store_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   // The two kind codes that the block leaves unused.
   localparam logic [2:0] KIND_SPARE_LO = 3'd6;
   localparam logic [2:0] KIND_SPARE_HI = 3'd7;
   localparam int QUIET_LIMIT = 2000;
   localparam int RANDOM_PER_PHASE = 234;
   localparam int BURST_LEN = 24;

   logic                              clock;
   logic                              reset;
   logic                              start;
   logic                              busy;
   logic [2:0]                        req_kind;
   logic signed [psq_pkg::DATA_W-1:0] req_value;
   logic [psq_pkg::POS_W-1:0]         req_position;
   logic                              rsp_valid;
   logic signed [psq_pkg::DATA_W-1:0] rsp_removed;
   logic [1:0]                        rsp_status;
   int                                failures;
   int                                pending;
   int                                sender_idle_pct;
   int                                quiet_cycles;

   positional_sequence_store_unit uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_kind(req_kind),
      .req_value(req_value),
      .req_position(req_position),
      .rsp_valid(rsp_valid),
      .rsp_removed(rsp_removed),
      .rsp_status(rsp_status)
   );

   psq_checker list_checker (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_kind(req_kind),
      .req_value(req_value),
      .req_position(req_position),
      .rsp_valid(rsp_valid),
      .rsp_removed(rsp_removed),
      .rsp_status(rsp_status),
      .failures(failures),
      .pending(pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // The run is ended when neither a transaction nor a response moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Presents one transaction, holds it until accepted, then maybe idles.
   // Called and returning at a rising edge.
   task automatic issue_request(logic [2:0] kind,
                                logic signed [psq_pkg::DATA_W-1:0] value,
                                logic [psq_pkg::POS_W-1:0] position);
      req_kind <= kind;
      req_value <= value;
      req_position <= position;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Random transaction whose mix leans toward inserts or deletes as asked.
   task automatic issue_random(int insert_pct);
      logic [2:0]                kind;
      logic [psq_pkg::POS_W-1:0] position;
      if ($urandom_range(99) < 3) begin
         kind = $urandom_range(1) ? KIND_SPARE_HI : KIND_SPARE_LO;
      end else if ($urandom_range(99) < insert_pct) begin
         case ($urandom_range(2))
            0: kind = psq_pkg::KIND_INS_FRONT;
            1: kind = psq_pkg::KIND_INS_END;
            default: kind = psq_pkg::KIND_INS_POS;
         endcase
      end else begin
         case ($urandom_range(2))
            0: kind = psq_pkg::KIND_DEL_FRONT;
            1: kind = psq_pkg::KIND_DEL_END;
            default: kind = psq_pkg::KIND_DEL_POS;
         endcase
      end
      // Mostly positions near the list length, sometimes anywhere in range.
      position = ($urandom_range(99) < 85) ?
                 psq_pkg::POS_W'($urandom_range(psq_pkg::DEPTH + 2)) :
                 psq_pkg::POS_W'($urandom_range(255));
      issue_request(kind, $urandom, position);
   endtask

   initial begin
      int insert_pct;
      logic [2:0] fill_kind;
      logic signed [psq_pkg::DATA_W-1:0] fill_value;
      reset = 1'b1;
      start = 1'b0;
      req_kind = psq_pkg::KIND_INS_FRONT;
      req_value = '0;
      req_position = '0;
      sender_idle_pct = 30;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Empty list: deletes report empty even with a bad position.
      issue_request(psq_pkg::KIND_DEL_FRONT, 32'sd5, 8'd1);
      issue_request(psq_pkg::KIND_DEL_POS, 32'sd5, 8'd0);
      // Positional insert into an empty list: only position 1 is legal.
      issue_request(psq_pkg::KIND_INS_POS, 32'sd11, 8'd0);
      issue_request(psq_pkg::KIND_INS_POS, 32'sd12, 8'd2);
      issue_request(psq_pkg::KIND_INS_POS, 32'sh7FFFFFFF, 8'd1);

      // Fill the list with every insert kind and the extreme values.
      for (int i = 0; i < psq_pkg::DEPTH - 1; i++) begin
         case (i % 3)
            0: fill_kind = psq_pkg::KIND_INS_FRONT;
            1: fill_kind = psq_pkg::KIND_INS_END;
            default: fill_kind = psq_pkg::KIND_INS_POS;
         endcase
         case (i)
            0: fill_value = 32'sh80000000;
            1: fill_value = -32'sd1;
            2: fill_value = '0;
            default: fill_value = $urandom;
         endcase
         issue_request(fill_kind, fill_value, psq_pkg::POS_W'(i / 2 + 1));
      end

      // Full list: inserts report full even with a bad position.
      issue_request(psq_pkg::KIND_INS_FRONT, 32'sd1, 8'd1);
      issue_request(psq_pkg::KIND_INS_POS, 32'sd2, 8'd255);
      // Delete positions out of range, then the head, the tail and the front.
      issue_request(psq_pkg::KIND_DEL_POS, 32'sd0, 8'd0);
      issue_request(psq_pkg::KIND_DEL_POS, 32'sd0, 8'(psq_pkg::DEPTH + 1));
      issue_request(psq_pkg::KIND_DEL_POS, 32'sd0, 8'd1);
      issue_request(psq_pkg::KIND_DEL_END, 32'sd0, 8'd0);
      issue_request(psq_pkg::KIND_DEL_FRONT, 32'sd0, 8'd0);
      // Spare kinds with an all-ones value and a 55AA55AA pattern.
      issue_request(KIND_SPARE_LO, -32'sd1, 8'd255);
      issue_request(KIND_SPARE_HI, 32'sh55AA55AA, 8'd128);

      // Random part in three idling phases; bursts swing the list between
      // empty and full so that both boundaries are visited repeatedly.
      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 78 : 0;
         insert_pct = 50;
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (n % BURST_LEN == 0) begin
               case ($urandom_range(2))
                  0: insert_pct = 85;
                  1: insert_pct = 50;
                  default: insert_pct = 15;
               endcase
            end
            issue_random(insert_pct);
         end
      end
      start <= 1'b0;

      // Drain the outstanding responses, then let the bench idle before reporting.
      do @(posedge clock); while (pending != 0);
      repeat (4) @(posedge clock);
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
